### sv/oproj_pkg.sv
// Package for the orbit perspective projection block.
// Holds the register map, register reset values and datapath constants.
// No dependencies.
package oproj_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int REG_ADDR_WIDTH = 5;
  localparam int REG_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    REG_COS_AZIMUTH   = 3'd0,
    REG_SIN_AZIMUTH   = 3'd1,
    REG_COS_ELEVATION = 3'd2,
    REG_SIN_ELEVATION = 3'd3,
    REG_VIEW_DISTANCE = 3'd4,
    REG_CENTER_X      = 3'd5,
    REG_CENTER_Y      = 3'd6
  } oproj_reg_t;

  localparam logic signed [15:0] RST_COS_AZIMUTH   = 16'sd15091;
  localparam logic signed [15:0] RST_SIN_AZIMUTH   = 16'sd6380;
  localparam logic signed [15:0] RST_COS_ELEVATION = 16'sd15391;
  localparam logic signed [15:0] RST_SIN_ELEVATION = 16'sd5618;
  localparam logic        [15:0] RST_VIEW_DISTANCE = 16'd4800;
  localparam logic signed [15:0] RST_CENTER_X      = 16'sd6400;
  localparam logic signed [15:0] RST_CENTER_Y      = 16'sd4320;

  // Depth floor of 0.01 in Q28.
  localparam longint DEPTH_FLOOR_Q28 = 64'd2684355;

endpackage

### sv/orbit_perspective_projection.sv
// Throughput: one beat per cycle while out_stall is low; the two restoring dividers retire one quotient
// bit per stage over COORD_WIDTH + 20 stages, which sets the pipeline depth.
// Each stage moves whenever its successor has room, so bubbles collapse under stall.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register defaults.
// Depends on oproj_pkg.
module orbit_perspective_projection import oproj_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_world_x,
  input  logic signed [COORD_WIDTH-1:0] in_world_y,
  input  logic signed [COORD_WIDTH-1:0] in_world_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_screen_x,
  output logic signed [COORD_WIDTH-1:0] out_screen_y,
  output logic                          out_depth_clamped,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [REG_ADDR_WIDTH-1:0]     paddr,
  input  logic [REG_DATA_WIDTH-1:0]     pwdata,
  output logic [REG_DATA_WIDTH-1:0]     prdata,
  output logic                          pready
);

  localparam int W    = COORD_WIDTH;
  localparam int MW   = W + 16;
  localparam int RW   = W + 17;
  localparam int OW   = W + 33;
  localparam int DZW  = OW + 1;
  localparam int DVW  = OW;
  localparam int NXW  = RW + 40;
  localparam int NYW  = OW + 26;
  localparam int QW   = W + 20;
  localparam int SW   = QW + 2;
  localparam int S_DIV0 = 5;
  localparam int NS   = QW + 7;
  localparam int S_OUT = NS - 1;

  // Configuration registers.
  logic signed [15:0] ca_r, sa_r, ce_r, se_r, cx_r, cy_r;
  logic        [15:0] vd_r;
  logic               wr_en;
  oproj_reg_t         wr_reg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_reg = oproj_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= RST_COS_AZIMUTH;
      sa_r <= RST_SIN_AZIMUTH;
      ce_r <= RST_COS_ELEVATION;
      se_r <= RST_SIN_ELEVATION;
      vd_r <= RST_VIEW_DISTANCE;
      cx_r <= RST_CENTER_X;
      cy_r <= RST_CENTER_Y;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_COS_AZIMUTH:   ca_r <= pwdata[15:0];
        REG_SIN_AZIMUTH:   sa_r <= pwdata[15:0];
        REG_COS_ELEVATION: ce_r <= pwdata[15:0];
        REG_SIN_ELEVATION: se_r <= pwdata[15:0];
        REG_VIEW_DISTANCE: vd_r <= pwdata[15:0];
        REG_CENTER_X:      cx_r <= pwdata[15:0];
        REG_CENTER_Y:      cy_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_reg)
      REG_COS_AZIMUTH:   prdata[15:0] = ca_r;
      REG_SIN_AZIMUTH:   prdata[15:0] = sa_r;
      REG_COS_ELEVATION: prdata[15:0] = ce_r;
      REG_SIN_ELEVATION: prdata[15:0] = se_r;
      REG_VIEW_DISTANCE: prdata[15:0] = vd_r;
      REG_CENTER_X:      prdata[15:0] = cx_r;
      REG_CENTER_Y:      prdata[15:0] = cy_r;
      default:           prdata = '0;
    endcase
  end

  // Valid bits and per-stage load enables.
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Stage 0: azimuth products.
  logic signed [MW-1:0] s0_xca_r, s0_zsa_r, s0_xsa_r, s0_zca_r;
  logic signed [W-1:0]  s0_y_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_xca_r <= MW'(in_world_x) * MW'(ca_r);
      s0_zsa_r <= MW'(in_world_z) * MW'(sa_r);
      s0_xsa_r <= MW'(in_world_x) * MW'(sa_r);
      s0_zca_r <= MW'(in_world_z) * MW'(ca_r);
      s0_y_r   <= in_world_y;
    end
  end

  // Stage 1: azimuth rotation sums.
  logic signed [RW-1:0] s1_rx_r, s1_rz_r;
  logic signed [W-1:0]  s1_y_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_rx_r <= RW'(s0_xca_r) + RW'(s0_zsa_r);
      s1_rz_r <= RW'(s0_zca_r) - RW'(s0_xsa_r);
      s1_y_r  <= s0_y_r;
    end
  end

  // Stage 2: elevation products.
  logic signed [OW-1:0] s2_rzse_r, s2_rzce_r;
  logic signed [MW-1:0] s2_yce_r, s2_yse_r;
  logic signed [RW-1:0] s2_rx_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_rzse_r <= OW'(s1_rz_r) * OW'(se_r);
      s2_rzce_r <= OW'(s1_rz_r) * OW'(ce_r);
      s2_yce_r  <= MW'(s1_y_r) * MW'(ce_r);
      s2_yse_r  <= MW'(s1_y_r) * MW'(se_r);
      s2_rx_r   <= s1_rx_r;
    end
  end

  // Stage 3: elevation sums, depth and floor.
  logic signed [OW-1:0]  s3_oy_nxt, s3_oz_nxt;
  logic signed [DZW-1:0] s3_dz_nxt;
  logic                  s3_clamp_nxt;
  logic signed [OW-1:0]  s3_oy_r;
  logic        [DVW-1:0] s3_dz_r;
  logic signed [RW-1:0]  s3_rx_r;
  logic                  s3_clamp_r;

  always_comb begin
    s3_oy_nxt = (OW'(s2_yce_r) <<< 14) - s2_rzse_r;
    s3_oz_nxt = (OW'(s2_yse_r) <<< 14) + s2_rzce_r;
    s3_dz_nxt = DZW'(s3_oz_nxt) + $signed({{(DZW-40){1'b0}}, vd_r, 24'd0});
    s3_clamp_nxt = s3_dz_nxt < $signed(DZW'(DEPTH_FLOOR_Q28));
    if (s3_clamp_nxt) s3_dz_nxt = $signed(DZW'(DEPTH_FLOOR_Q28));
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_oy_r    <= s3_oy_nxt;
      s3_dz_r    <= s3_dz_nxt[DVW-1:0];
      s3_rx_r    <= s2_rx_r;
      s3_clamp_r <= s3_clamp_nxt;
    end
  end

  // Stage 4: offset numerators.
  logic [RW-1:0]  s4_ax;
  logic [OW-1:0]  s4_ay;
  logic [RW+15:0] s4_nx_r;
  logic [OW+15:0] s4_ny_r;
  logic [DVW-1:0] s4_dz_r;
  logic           s4_sx_r, s4_sy_r, s4_clamp_r;

  assign s4_ax = s3_rx_r[RW-1] ? RW'(-s3_rx_r) : RW'(s3_rx_r);
  assign s4_ay = s3_oy_r[OW-1] ? OW'(-s3_oy_r) : OW'(s3_oy_r);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_nx_r    <= (RW+16)'(s4_ax) * (RW+16)'(vd_r);
      s4_ny_r    <= (OW+16)'(s4_ay) * (OW+16)'(vd_r);
      s4_dz_r    <= s3_dz_r;
      s4_sx_r    <= s3_rx_r[RW-1];
      s4_sy_r    <= s3_oy_r[OW-1];
      s4_clamp_r <= s3_clamp_r;
    end
  end

  // Stage 5 and onward: two restoring dividers sharing the depth divisor.
  logic [NXW-1:0] dv_nx;
  logic [NYW-1:0] dv_ny;
  logic [DVW-1:0] dv_rem_x_r [0:QW];
  logic [DVW-1:0] dv_rem_y_r [0:QW];
  logic [QW-1:0]  dv_sh_x_r  [0:QW];
  logic [QW-1:0]  dv_sh_y_r  [0:QW];
  logic [DVW-1:0] dv_dz_r    [0:QW];
  logic [QW:0]    dv_ovf_x_r, dv_ovf_y_r, dv_sx_r, dv_sy_r, dv_clamp_r;

  assign dv_nx = {s4_nx_r, 24'd0};
  assign dv_ny = {s4_ny_r, 10'd0};

  always_ff @(posedge clk) begin
    if (rdy[S_DIV0]) begin
      dv_rem_x_r[0] <= DVW'(dv_nx[NXW-1:QW]);
      dv_rem_y_r[0] <= DVW'(dv_ny[NYW-1:QW]);
      dv_sh_x_r[0]  <= dv_nx[QW-1:0];
      dv_sh_y_r[0]  <= dv_ny[QW-1:0];
      dv_ovf_x_r[0] <= DVW'(dv_nx[NXW-1:QW]) >= s4_dz_r;
      dv_ovf_y_r[0] <= DVW'(dv_ny[NYW-1:QW]) >= s4_dz_r;
      dv_dz_r[0]    <= s4_dz_r;
      dv_sx_r[0]    <= s4_sx_r;
      dv_sy_r[0]    <= s4_sy_r;
      dv_clamp_r[0] <= s4_clamp_r;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DVW:0] tx, ty;
    logic         gex, gey;

    assign tx  = {dv_rem_x_r[k-1], dv_sh_x_r[k-1][QW-1]};
    assign ty  = {dv_rem_y_r[k-1], dv_sh_y_r[k-1][QW-1]};
    assign gex = tx >= {1'b0, dv_dz_r[k-1]};
    assign gey = ty >= {1'b0, dv_dz_r[k-1]};

    always_ff @(posedge clk) begin
      if (rdy[S_DIV0+k]) begin
        dv_rem_x_r[k] <= gex ? DVW'(tx - {1'b0, dv_dz_r[k-1]}) : tx[DVW-1:0];
        dv_rem_y_r[k] <= gey ? DVW'(ty - {1'b0, dv_dz_r[k-1]}) : ty[DVW-1:0];
        dv_sh_x_r[k]  <= {dv_sh_x_r[k-1][QW-2:0], gex};
        dv_sh_y_r[k]  <= {dv_sh_y_r[k-1][QW-2:0], gey};
        dv_ovf_x_r[k] <= dv_ovf_x_r[k-1];
        dv_ovf_y_r[k] <= dv_ovf_y_r[k-1];
        dv_dz_r[k]    <= dv_dz_r[k-1];
        dv_sx_r[k]    <= dv_sx_r[k-1];
        dv_sy_r[k]    <= dv_sy_r[k-1];
        dv_clamp_r[k] <= dv_clamp_r[k-1];
      end
    end
  end

  // Output stage: add the center, truncate toward zero, saturate.
  localparam logic signed [SW-1:0] LIM_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LIM_LO = -LIM_HI - SW'(1);

  logic [QW-1:0]        qx, qy;
  logic signed [SW-1:0] offx, offy, sumx, sumy, divx, divy;
  logic signed [W-1:0]  scr_x_nxt, scr_y_nxt;
  logic signed [W-1:0]  out_screen_x_r, out_screen_y_r;
  logic                 out_depth_clamped_r;

  always_comb begin
    qx   = dv_ovf_x_r[QW] ? '1 : dv_sh_x_r[QW];
    qy   = dv_ovf_y_r[QW] ? '1 : dv_sh_y_r[QW];
    offx = dv_sx_r[QW] ? -$signed(SW'(qx)) : $signed(SW'(qx));
    offy = dv_sy_r[QW] ? $signed(SW'(qy)) : -$signed(SW'(qy));
    sumx = (SW'(cx_r) <<< 10) + offx;
    sumy = (SW'(cy_r) <<< 10) + offy;
    divx = sumx[SW-1] ? ((sumx + SW'(16383)) >>> 14) : (sumx >>> 14);
    divy = sumy[SW-1] ? ((sumy + SW'(16383)) >>> 14) : (sumy >>> 14);
    if (divx > LIM_HI)      scr_x_nxt = W'(LIM_HI);
    else if (divx < LIM_LO) scr_x_nxt = W'(LIM_LO);
    else                    scr_x_nxt = W'(divx);
    if (divy > LIM_HI)      scr_y_nxt = W'(LIM_HI);
    else if (divy < LIM_LO) scr_y_nxt = W'(LIM_LO);
    else                    scr_y_nxt = W'(divy);
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      out_screen_x_r      <= scr_x_nxt;
      out_screen_y_r      <= scr_y_nxt;
      out_depth_clamped_r <= dv_clamp_r[QW];
    end
  end

  assign out_valid         = vld_r[S_OUT];
  assign out_screen_x      = out_screen_x_r;
  assign out_screen_y      = out_screen_y_r;
  assign out_depth_clamped = out_depth_clamped_r;

endmodule

### tb/tb_orbit_perspective_projection.sv
// Self-checking testbench for orbit_perspective_projection: a stimulus table, then random points.
// Results checked against a fixed-point predictor or table values, under several register sets.
// Depends on oproj_pkg and the orbit_perspective_projection RTL.
module tb_orbit_perspective_projection import oproj_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int LATENCY = CW + 27;
  localparam longint CYCLE_LIMIT = 600000;
  localparam logic [127:0] OFF_CAP = 128'(1) << 62;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 clamped;
  } screen_t;

  typedef struct {
    logic signed [CW-1:0] wx;
    logic signed [CW-1:0] wy;
    logic signed [CW-1:0] wz;
    bit                   known;
    screen_t              res;
  } point_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_world_x = '0, in_world_y = '0, in_world_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [CW-1:0] out_screen_x, out_screen_y;
  logic out_depth_clamped;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [REG_ADDR_WIDTH-1:0] paddr = '0;
  logic [REG_DATA_WIDTH-1:0] pwdata = '0;
  logic [REG_DATA_WIDTH-1:0] prdata;
  logic pready;

  logic [15:0] regs_shadow [7];
  screen_t expected_screens[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  orbit_perspective_projection #(.COORD_WIDTH(CW)) dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [CW-1:0] saturate(longint c, longint off);
    longint v;
    longint lim;
    lim = (longint'(1) << (CW - 1)) - 1;
    v = (c * 1024 + off) / 16384;
    if (v > lim) v = lim;
    if (v < -lim - 1) v = -lim - 1;
    return v[CW-1:0];
  endfunction

  function automatic logic [127:0] scaled_quotient(logic [127:0] a, logic [127:0] b,
                                                   logic [127:0] d);
    logic [127:0] q;
    q = (a * b) / d;
    return (q > OFF_CAP) ? OFF_CAP : q;
  endfunction

  function automatic screen_t project(logic signed [CW-1:0] wx, logic signed [CW-1:0] wy,
                                      logic signed [CW-1:0] wz);
    longint x, y, z, ca, sa, ce, se, vd, cx, cy;
    longint rx, rz, oy, oz, dz, offx, offy;
    logic [127:0] mx, my;
    screen_t r;
    x = wx; y = wy; z = wz;
    ca = $signed(regs_shadow[REG_COS_AZIMUTH]);
    sa = $signed(regs_shadow[REG_SIN_AZIMUTH]);
    ce = $signed(regs_shadow[REG_COS_ELEVATION]);
    se = $signed(regs_shadow[REG_SIN_ELEVATION]);
    vd = longint'(regs_shadow[REG_VIEW_DISTANCE]);
    cx = $signed(regs_shadow[REG_CENTER_X]);
    cy = $signed(regs_shadow[REG_CENTER_Y]);
    rx = x * ca + z * sa;
    rz = z * ca - x * sa;
    oy = y * ce * 16384 - rz * se;
    oz = y * se * 16384 + rz * ce;
    dz = oz + (vd << 24);
    r.clamped = 1'b0;
    if (dz < DEPTH_FLOOR_Q28) begin
      dz = DEPTH_FLOOR_Q28;
      r.clamped = 1'b1;
    end
    mx = scaled_quotient(128'(rx < 0 ? -rx : rx), 128'(vd) << 24, 128'(dz));
    my = scaled_quotient(128'(oy < 0 ? -oy : oy), 128'(vd) << 10, 128'(dz));
    offx = rx < 0 ? -longint'(mx[63:0]) : longint'(mx[63:0]);
    offy = oy < 0 ? longint'(my[63:0]) : -longint'(my[63:0]);
    r.sx = saturate(cx, offx);
    r.sy = saturate(cy, offy);
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    screen_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_screen_x, out_screen_y, out_depth_clamped};
      if (expected_screens.size() == 0) begin
        $display("%0t: unexpected beat, actual %0d %0d %0d", $time,
                 got.sx, got.sy, got.clamped);
        errors++;
      end else begin
        want = expected_screens.pop_front();
        if (got.sx !== want.sx) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, want.sx, got.sx);
          errors++;
        end
        if (got.sy !== want.sy) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, want.sy, got.sy);
          errors++;
        end
        if (got.clamped !== want.clamped) begin
          $display("%0t: depth_clamped expected %0d actual %0d", $time,
                   want.clamped, got.clamped);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(oproj_reg_t idx, logic [15:0] value);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= REG_ADDR_WIDTH'(idx) << 2;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    regs_shadow[idx] = value;
  endtask

  task automatic write_all(logic [15:0] ca, logic [15:0] sa, logic [15:0] ce,
                           logic [15:0] se, logic [15:0] vd, logic [15:0] cx,
                           logic [15:0] cy);
    write_reg(REG_COS_AZIMUTH, ca);
    write_reg(REG_SIN_AZIMUTH, sa);
    write_reg(REG_COS_ELEVATION, ce);
    write_reg(REG_SIN_ELEVATION, se);
    write_reg(REG_VIEW_DISTANCE, vd);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (expected_screens.size() != 0) @(posedge clk);
  endtask

  task automatic send_point(logic signed [CW-1:0] wx, logic signed [CW-1:0] wy,
                            logic signed [CW-1:0] wz, bit known, screen_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_world_x <= wx; in_world_y <= wy; in_world_z <= wz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_screens.push_back(known ? res : project(wx, wy, wz));
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CW'($urandom_range(200)) - CW'(100);
      1: return CW'($urandom_range(4000)) - CW'(2000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(32768)) - 16'd16384;
  endfunction

  point_row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1, '{16'sd400, 16'sd270, 1'b0}},
    '{16'sd32767, 16'sd32767, 16'sd32767, 0, '0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 0, '0},
    '{16'sd32767, -16'sd32768, 16'sd0, 0, '0},
    '{-16'sd32768, 16'sd32767, 16'sd0, 0, '0},
    '{16'sd0, 16'sd0, -16'sd32768, 0, '0},
    '{16'sd0, 16'sd0, 16'sd32767, 0, '0},
    '{16'sd0, -16'sd32768, 16'sd0, 0, '0},
    '{16'sd0, 16'sd32767, 16'sd0, 0, '0},
    '{16'sd1, -16'sd1, 16'sd1, 0, '0},
    '{-16'sd1, 16'sd1, -16'sd1, 0, '0},
    '{16'sd100, 16'sd50, -16'sd4000, 0, '0},
    '{16'sd100, 16'sd50, -16'sd5600, 0, '0},
    '{16'sd5461, 16'sd10922, 16'sd21845, 0, '0},
    '{-16'sd21846, -16'sd10923, -16'sd5462, 0, '0}
  };

  initial begin
    regs_shadow[REG_COS_AZIMUTH] = RST_COS_AZIMUTH;
    regs_shadow[REG_SIN_AZIMUTH] = RST_SIN_AZIMUTH;
    regs_shadow[REG_COS_ELEVATION] = RST_COS_ELEVATION;
    regs_shadow[REG_SIN_ELEVATION] = RST_SIN_ELEVATION;
    regs_shadow[REG_VIEW_DISTANCE] = RST_VIEW_DISTANCE;
    regs_shadow[REG_CENTER_X] = RST_CENTER_X;
    regs_shadow[REG_CENTER_Y] = RST_CENTER_Y;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed[i])
      send_point(directed[i].wx, directed[i].wy, directed[i].wz, directed[i].known,
                 directed[i].res);
    in_valid <= 0;
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      @(posedge clk);
      case (ph)
        0: write_all(16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, 16'hFFFF,
                     16'sd32767, -16'sd32768);
        1: write_all(-16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, 16'd1,
                     -16'sd32768, 16'sd32767);
        2: write_all(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0);
        3: write_all(RST_COS_AZIMUTH, RST_SIN_AZIMUTH, RST_COS_ELEVATION,
                     RST_SIN_ELEVATION, RST_VIEW_DISTANCE, RST_CENTER_X, RST_CENTER_Y);
        default: write_all(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                           ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(8000, 1)),
                           16'($urandom), 16'($urandom));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 83; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 83; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 125; n++) begin
        if (ph == 5 && n == 60) begin
          in_valid <= 0;
          drain();
        end
        send_point(rand_coord(), rand_coord(), rand_coord(), 0, '0);
      end
      in_valid <= 0;
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
